/* rtl/core/cspa_pkg.sv */
// call stack profile aggregator: shared package
// command and status codes, table cell control bundle; no dependencies
`timescale 1ns / 1ps

package cspa_pkg;

	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_END   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_STACK_FUL = 3'd1;
	localparam logic [2:0] ST_TABLE_FUL = 3'd2;
	localparam logic [2:0] ST_MISMATCH  = 3'd3;
	localparam logic [2:0] ST_BAD_INDEX = 3'd4;

	typedef struct packed {
		logic        load;
		logic        acc;
		logic [31:0] key;
		logic [63:0] dt;
	} cell_ctl_t;

endpackage

/* rtl/core/call_stack_profile_aggregator.sv */
// call stack profile aggregator top level
// depends on cspa_pkg, cspa_cell, cspa_ram
//
// usage: an event (command, region_key, timestamp, read_index) is taken at a
// rising edge with start high and busy low. busy stays high while the event is
// worked. its one result appears on the output ports for exactly one cycle
// with done high; the receiver cannot stall and must take it then.
// cfg_we/cfg_wdata write strict_matching (1 = end must match the top frame).
// begin/end walk a search token along the row of table cells, one cell per
// cycle; an end in recovery mode then reads the stack ram one frame at a
// time, from the top frame downwards, until the frame's slot matches.
// the next event can be taken in the cycle done is shown.
// reset clears counters, stack depth, used slots and sets strict mode;
// table and stack contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module call_stack_profile_aggregator #(
	parameter int TABLE_SLOTS  = 32,
	parameter int STACK_FRAMES = 128,
	parameter int KEY_BITS     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] region_key,
	input  logic [63:0] timestamp,
	input  logic [4:0]  read_index,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output logic        done,
	output logic [2:0]  status,
	output logic [4:0]  entry_index,
	output logic [31:0] entry_key,
	output logic [31:0] entry_calls,
	output logic [63:0] entry_total,
	output logic [63:0] last_duration,
	output logic [7:0]  stack_depth,
	output logic [5:0]  entries_used,
	output logic [31:0] mismatch_count,
	output logic [31:0] stack_full_count,
	output logic [31:0] table_full_count
);

	localparam int KW  = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int IW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int UCW = $clog2(TABLE_SLOTS + 1);
	localparam int AW  = (STACK_FRAMES > 1) ? $clog2(STACK_FRAMES) : 1;
	localparam int FCW = $clog2(STACK_FRAMES + 1);
	localparam int DW  = IW + 64;

	typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_RD, S_CHK, S_UPD, S_OUT} state_t;

	state_t         state_q;
	logic           strict_q;
	logic [UCW-1:0] used_q;
	logic [FCW-1:0] fc_q;
	logic [31:0]    mism_q, srf_q, trf_q;
	logic [1:0]     cmd_q;
	logic [31:0]    key_q;
	logic [63:0]    ts_q, dur_q;
	logic [2:0]     stat_q;
	logic           ent_q, new_q, inject_q;
	logic [IW-1:0]  cur_q, cnt_q;
	logic [AW-1:0]  j_q;

	logic        done_q;
	logic [2:0]  status_q;
	logic [4:0]  eidx_q;
	logic [31:0] ekey_q, ecalls_q;
	logic [63:0] etotal_q, ldur_q;
	logic [7:0]  depth_q;
	logic [5:0]  eused_q;

	cspa_pkg::cell_ctl_t ctl;
	logic [TABLE_SLOTS:0]   tok;
	logic [TABLE_SLOTS-1:0] hit_v, dead_v;
	logic [KW-1:0]          c_key   [TABLE_SLOTS];
	logic [31:0]            c_calls [TABLE_SLOTS];
	logic [63:0]            c_total [TABLE_SLOTS];
	logic                   hit_any, miss_any;

	logic          ram_we;
	logic [DW-1:0] ram_rdata;
	logic [IW-1:0] fr_slot;
	logic [63:0]   fr_start;

	assign ctl.load = (state_q == S_UPD) && (cmd_q == cspa_pkg::CMD_BEGIN) && new_q;
	assign ctl.acc  = (state_q == S_UPD) && (cmd_q == cspa_pkg::CMD_END);
	assign ctl.key  = key_q;
	assign ctl.dt   = dur_q;

	assign tok[0] = inject_q;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_SLOTS; gi++) begin : g_cell
			cspa_cell #(.KW(KW)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (tok[gi]),
				.valid   (UCW'(gi) < used_q),
				.sel     (cur_q == IW'(gi)),
				.ctl     (ctl),
				.tok_out (tok[gi+1]),
				.hit     (hit_v[gi]),
				.dead    (dead_v[gi]),
				.key_o   (c_key[gi]),
				.calls_o (c_calls[gi]),
				.total_o (c_total[gi])
			);
		end
	endgenerate

	assign hit_any  = |hit_v;
	assign miss_any = (|dead_v) | tok[TABLE_SLOTS];

	assign ram_we = (state_q == S_UPD) && (cmd_q == cspa_pkg::CMD_BEGIN);

	cspa_ram #(.WIDTH(DW), .DEPTH(STACK_FRAMES)) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(fc_q)),
		.wdata ({cur_q, ts_q}),
		.raddr (j_q),
		.rdata (ram_rdata)
	);

	assign fr_slot  = ram_rdata[DW-1:64];
	assign fr_start = ram_rdata[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strict_q <= 1'b1;
			used_q   <= '0;
			fc_q     <= '0;
			mism_q   <= '0;
			srf_q    <= '0;
			trf_q    <= '0;
			done_q   <= 1'b0;
			inject_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			inject_q <= 1'b0;
			if (cfg_we) begin
				strict_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q  <= command;
						key_q  <= region_key;
						ts_q   <= timestamp;
						dur_q  <= '0;
						stat_q <= cspa_pkg::ST_OK;
						ent_q  <= 1'b0;
						new_q  <= 1'b0;
						cnt_q  <= '1;
						state_q <= S_OUT;
						unique case (command)
							cspa_pkg::CMD_BEGIN: begin
								if (fc_q >= FCW'(STACK_FRAMES)) begin
									srf_q  <= srf_q + 32'd1;
									stat_q <= cspa_pkg::ST_STACK_FUL;
								end else begin
									inject_q <= 1'b1;
									state_q  <= S_SEARCH;
								end
							end
							cspa_pkg::CMD_END: begin
								if (fc_q == '0) begin
									mism_q <= mism_q + 32'd1;
									stat_q <= cspa_pkg::ST_MISMATCH;
								end else begin
									inject_q <= 1'b1;
									state_q  <= S_SEARCH;
								end
							end
							cspa_pkg::CMD_READ: begin
								if ((32'(read_index) < 32'(used_q)) &&
								    (32'(read_index) < 32'(TABLE_SLOTS))) begin
									cur_q <= IW'(read_index);
									ent_q <= 1'b1;
								end else begin
									stat_q <= cspa_pkg::ST_BAD_INDEX;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (hit_any) begin
						cur_q <= cnt_q;
						if (cmd_q == cspa_pkg::CMD_BEGIN) begin
							state_q <= S_UPD;
						end else begin
							j_q     <= AW'(fc_q - FCW'(1));
							state_q <= S_RD;
						end
					end else if (miss_any) begin
						if (cmd_q == cspa_pkg::CMD_BEGIN) begin
							if (used_q < UCW'(TABLE_SLOTS)) begin
								cur_q   <= IW'(used_q);
								new_q   <= 1'b1;
								used_q  <= used_q + UCW'(1);
								state_q <= S_UPD;
							end else begin
								trf_q   <= trf_q + 32'd1;
								stat_q  <= cspa_pkg::ST_TABLE_FUL;
								state_q <= S_OUT;
							end
						end else begin
							mism_q  <= mism_q + 32'd1;
							stat_q  <= cspa_pkg::ST_MISMATCH;
							state_q <= S_OUT;
						end
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (fr_slot == cur_q) begin
						dur_q   <= ts_q - fr_start;
						fc_q    <= FCW'(j_q);
						state_q <= S_UPD;
					end else if (strict_q || (j_q == '0)) begin
						mism_q  <= mism_q + 32'd1;
						stat_q  <= cspa_pkg::ST_MISMATCH;
						state_q <= S_OUT;
					end else begin
						j_q     <= j_q - AW'(1);
						state_q <= S_RD;
					end
				end
				S_UPD: begin
					if (cmd_q == cspa_pkg::CMD_BEGIN) begin
						fc_q <= fc_q + FCW'(1);
					end
					ent_q   <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q   <= 1'b1;
					status_q <= stat_q;
					ldur_q   <= dur_q;
					depth_q  <= 8'(fc_q);
					eused_q  <= 6'(used_q);
					if (ent_q) begin
						eidx_q   <= 5'(cur_q);
						ekey_q   <= 32'(c_key[cur_q]);
						ecalls_q <= c_calls[cur_q];
						etotal_q <= c_total[cur_q];
					end else begin
						eidx_q   <= '0;
						ekey_q   <= '0;
						ecalls_q <= '0;
						etotal_q <= '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign status           = status_q;
	assign entry_index      = eidx_q;
	assign entry_key        = ekey_q;
	assign entry_calls      = ecalls_q;
	assign entry_total      = etotal_q;
	assign last_duration    = ldur_q;
	assign stack_depth      = depth_q;
	assign entries_used     = eused_q;
	assign mismatch_count   = mism_q;
	assign stack_full_count = srf_q;
	assign table_full_count = trf_q;

endmodule

/* rtl/core/cspa_ram.sv */
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cspa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/cspa_cell.sv */
// one table cell: key, call count and tick total plus a search token stage
// depends on cspa_pkg
`timescale 1ns / 1ps

module cspa_cell #(
	parameter int KW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_in,
	input  logic               valid,
	input  logic               sel,
	input  cspa_pkg::cell_ctl_t ctl,
	output logic               tok_out,
	output logic               hit,
	output logic               dead,
	output logic [KW-1:0]      key_o,
	output logic [31:0]        calls_o,
	output logic [63:0]        total_o
);

	logic          tok_q;
	logic [KW-1:0] key_q;
	logic [31:0]   calls_q;
	logic [63:0]   total_q;
	logic          match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && ctl.load) begin
			key_q   <= ctl.key[KW-1:0];
			calls_q <= 32'd0;
			total_q <= 64'd0;
		end else if (sel && ctl.acc) begin
			calls_q <= calls_q + 32'd1;
			total_q <= total_q + ctl.dt;
		end
	end

	assign match   = (key_q == ctl.key[KW-1:0]);
	assign hit     = tok_q & valid & match;
	assign tok_out = tok_q & valid & ~match;
	assign dead    = tok_q & ~valid;
	assign key_o   = key_q;
	assign calls_o = calls_q;
	assign total_o = total_q;

endmodule

/* rtl/core/cspa_chk.sv */
// port level checks for the call stack profile aggregator
// bound to call_stack_profile_aggregator; depends on cspa_pkg
`timescale 1ns / 1ps

module cspa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [31:0] entry_calls,
	input logic [63:0] entry_total,
	input logic [63:0] last_duration
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transfer did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != cspa_pkg::ST_OK) |-> (entry_calls == 32'd0 &&
		entry_total == 64'd0 && last_duration == 64'd0))
		else $error("entry fields set on refused event");

endmodule

bind call_stack_profile_aggregator cspa_chk u_cspa_chk (.*);

/* dv/tb_call_stack_profile_aggregator.sv */
// testbench for call_stack_profile_aggregator: directed and random event streams
// checked against an in-bench model of the call stack and region table
// depends on cspa_pkg and the call_stack_profile_aggregator rtl
`timescale 1ns / 1ps

module tb_call_stack_profile_aggregator;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SLOTS = 32;
	localparam int FRAMES = 128;
	localparam int POOL = 20;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  index;
		logic [31:0] key;
		logic [31:0] calls;
		logic [63:0] total;
		logic [63:0] dur;
		logic [7:0]  depth;
		logic [5:0]  used;
		logic [31:0] mis;
		logic [31:0] sfull;
		logic [31:0] tfull;
	} profile_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [31:0] region_key;
	logic [63:0] timestamp;
	logic [4:0]  read_index;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        done;
	logic [2:0]  status;
	logic [4:0]  entry_index;
	logic [31:0] entry_key;
	logic [31:0] entry_calls;
	logic [63:0] entry_total;
	logic [63:0] last_duration;
	logic [7:0]  stack_depth;
	logic [5:0]  entries_used;
	logic [31:0] mismatch_count;
	logic [31:0] stack_full_count;
	logic [31:0] table_full_count;

	// model of the profiler
	logic [31:0] m_key [SLOTS];
	logic [31:0] m_calls [SLOTS];
	logic [63:0] m_total [SLOTS];
	logic [4:0]  m_frame_slot [FRAMES];
	logic [63:0] m_frame_start [FRAMES];
	int          m_used;
	int          m_depth;
	logic [31:0] m_mis;
	logic [31:0] m_sfull;
	logic [31:0] m_tfull;
	logic        m_strict;

	profile_result_t expected_q [$];
	logic [31:0] key_pool [POOL];
	logic [63:0] now_ts;
	int          failures;
	int          quiet_cycles;
	int          burst_left;

	call_stack_profile_aggregator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .region_key(region_key), .timestamp(timestamp),
		.read_index(read_index), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .status(status), .entry_index(entry_index),
		.entry_key(entry_key), .entry_calls(entry_calls), .entry_total(entry_total),
		.last_duration(last_duration), .stack_depth(stack_depth),
		.entries_used(entries_used), .mismatch_count(mismatch_count),
		.stack_full_count(stack_full_count), .table_full_count(table_full_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic profile_result_t predict_event(input logic [1:0] cmd,
			input logic [31:0] key, input logic [63:0] ts, input logic [4:0] idx);
		profile_result_t r;
		int s;
		int top;
		int j;
		bit found;
		r = '0;
		if (cmd == cspa_pkg::CMD_BEGIN) begin
			if (m_depth >= FRAMES) begin
				m_sfull++;
				r.status = cspa_pkg::ST_STACK_FUL;
			end else begin
				found = 0;
				s = 0;
				for (j = 0; j < m_used; j++) begin
					if (!found && m_key[j] == key) begin
						s = j;
						found = 1;
					end
				end
				if (!found && m_used < SLOTS) begin
					s = m_used;
					m_used++;
					m_key[s] = key;
					m_calls[s] = '0;
					m_total[s] = '0;
					found = 1;
				end
				if (!found) begin
					m_tfull++;
					r.status = cspa_pkg::ST_TABLE_FUL;
				end else begin
					m_frame_slot[m_depth] = s[4:0];
					m_frame_start[m_depth] = ts;
					m_depth++;
					r.index = s[4:0];
					r.key = m_key[s];
					r.calls = m_calls[s];
					r.total = m_total[s];
				end
			end
		end else if (cmd == cspa_pkg::CMD_END) begin
			found = 0;
			top = m_depth - 1;
			if (m_depth > 0) begin
				if (m_key[m_frame_slot[top]] == key) begin
					found = 1;
				end else if (!m_strict) begin
					for (j = top - 1; j >= 0 && !found; j--) begin
						if (m_key[m_frame_slot[j]] == key) begin
							found = 1;
							top = j;
						end
					end
				end
			end
			if (!found) begin
				m_mis++;
				r.status = cspa_pkg::ST_MISMATCH;
			end else begin
				s = m_frame_slot[top];
				r.dur = ts - m_frame_start[top];
				m_depth = top;
				m_calls[s]++;
				m_total[s] += r.dur;
				r.index = s[4:0];
				r.key = m_key[s];
				r.calls = m_calls[s];
				r.total = m_total[s];
			end
		end else if (cmd == cspa_pkg::CMD_READ) begin
			if (idx < m_used) begin
				r.index = idx;
				r.key = m_key[idx];
				r.calls = m_calls[idx];
				r.total = m_total[idx];
			end else begin
				r.status = cspa_pkg::ST_BAD_INDEX;
			end
		end
		r.depth = m_depth[7:0];
		r.used = m_used[5:0];
		r.mis = m_mis;
		r.sfull = m_sfull;
		r.tfull = m_tfull;
		return r;
	endfunction

	task automatic send_event(input logic [1:0] cmd, input logic [31:0] key,
			input logic [63:0] ts, input logic [4:0] idx);
		int gap;
		gap = $urandom_range(0, 4);
		if (burst_left == 0 && $urandom_range(0, 15) == 0)
			burst_left = $urandom_range(5, 30);
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		command <= cmd;
		region_key <= key;
		timestamp <= ts;
		read_index <= idx;
		do @(posedge clk); while (busy);
		expected_q.push_back(predict_event(cmd, key, ts, idx));
	endtask

	function automatic logic [63:0] next_ts();
		now_ts += 64'($urandom_range(1, 2000));
		return now_ts;
	endfunction

	function automatic logic [31:0] top_key();
		return m_key[m_frame_slot[m_depth - 1]];
	endfunction

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_strict(input logic value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		m_strict = value;
	endtask

	task automatic unwind();
		while (m_depth > 0)
			send_event(cspa_pkg::CMD_END, top_key(), next_ts(), 5'($urandom));
	endtask

	task automatic test_directed();
		send_event(cspa_pkg::CMD_READ, 32'h0, 64'h0, 5'd0);
		send_event(cspa_pkg::CMD_READ, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd31);
		send_event(cspa_pkg::CMD_END, 32'h1234_5678, 64'h10, 5'd3);
		send_event(CMD_UNUSED, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd31);
		send_event(cspa_pkg::CMD_BEGIN, 32'h0, 64'h0, 5'd0);
		send_event(cspa_pkg::CMD_BEGIN, 32'hffff_ffff, 64'hffff_ffff_ffff_fff0, 5'd31);
		send_event(cspa_pkg::CMD_END, 32'h0, 64'h5, 5'd0);
		send_event(cspa_pkg::CMD_END, 32'hffff_ffff, 64'h20, 5'd0);
		send_event(cspa_pkg::CMD_BEGIN, 32'h0, 64'h100, 5'd0);
		send_event(cspa_pkg::CMD_END, 32'h0, 64'hffff_ffff_ffff_ffff, 5'd0);
		send_event(cspa_pkg::CMD_READ, 32'h0, 64'h0, 5'd0);
		send_event(cspa_pkg::CMD_READ, 32'h0, 64'h0, 5'd1);
		send_event(cspa_pkg::CMD_READ, 32'h0, 64'h0, 5'd2);
		send_event(cspa_pkg::CMD_END, 32'h0, 64'h0, 5'd0);
		send_event(cspa_pkg::CMD_BEGIN, key_pool[0], 64'h200, 5'd0);
		send_event(cspa_pkg::CMD_READ, 32'h0, 64'h0, 5'd2);
		send_event(cspa_pkg::CMD_END, key_pool[0], 64'h300, 5'd0);
		now_ts = 64'h1000;
	endtask

	task automatic test_stack_full();
		while (m_depth < FRAMES)
			send_event(cspa_pkg::CMD_BEGIN, key_pool[$urandom_range(0, POOL - 1)],
				next_ts(), 5'd0);
		send_event(cspa_pkg::CMD_BEGIN, key_pool[1], next_ts(), 5'd0);
		send_event(cspa_pkg::CMD_BEGIN, 32'hdead_beef, next_ts(), 5'd0);
		unwind();
	endtask

	task automatic test_recovery();
		write_strict(1'b0);
		send_event(cspa_pkg::CMD_BEGIN, key_pool[2], next_ts(), 5'd0);
		send_event(cspa_pkg::CMD_BEGIN, key_pool[3], next_ts(), 5'd0);
		send_event(cspa_pkg::CMD_BEGIN, key_pool[4], next_ts(), 5'd0);
		send_event(cspa_pkg::CMD_END, key_pool[2], next_ts(), 5'd0);
		send_event(cspa_pkg::CMD_BEGIN, key_pool[5], next_ts(), 5'd0);
		send_event(cspa_pkg::CMD_BEGIN, key_pool[6], next_ts(), 5'd0);
		send_event(cspa_pkg::CMD_END, 32'hffff_ffff, next_ts(), 5'd0);
		send_event(cspa_pkg::CMD_END, key_pool[6], next_ts(), 5'd0);
		send_event(cspa_pkg::CMD_END, key_pool[5], next_ts(), 5'd0);
	endtask

	task automatic test_random(input int count);
		int pick;
		logic [31:0] key;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45 && !(m_depth > 60 && $urandom_range(0, 1) == 0)) begin
				send_event(cspa_pkg::CMD_BEGIN, key_pool[$urandom_range(0, POOL - 1)],
					next_ts(), 5'($urandom));
			end else if (pick < 88) begin
				if (m_depth == 0 || $urandom_range(0, 9) == 0)
					key = key_pool[$urandom_range(0, POOL - 1)];
				else if (!m_strict && $urandom_range(0, 2) == 0)
					key = m_key[m_frame_slot[$urandom_range(0, m_depth - 1)]];
				else
					key = top_key();
				send_event(cspa_pkg::CMD_END, key, next_ts(), 5'($urandom));
			end else if (pick < 97) begin
				send_event(cspa_pkg::CMD_READ, $urandom, next_ts(), 5'($urandom));
			end else begin
				send_event(2'($urandom), $urandom, {$urandom, $urandom}, 5'($urandom));
			end
		end
	endtask

	task automatic test_table_full();
		unwind();
		repeat (40)
			send_event(cspa_pkg::CMD_BEGIN, $urandom, next_ts(), 5'd0);
		for (int i = 0; i < SLOTS; i++)
			send_event(cspa_pkg::CMD_READ, 32'h0, next_ts(), 5'(i));
		unwind();
		test_random(100);
	endtask

	function automatic int check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin
		profile_result_t e;
		int bad;
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("result transfer with no event outstanding");
				failures++;
			end else begin
				e = expected_q.pop_front();
				bad = 0;
				bad += check_field("status", e.status, status);
				bad += check_field("entry_index", e.index, entry_index);
				bad += check_field("entry_key", e.key, entry_key);
				bad += check_field("entry_calls", e.calls, entry_calls);
				bad += check_field("entry_total", e.total, entry_total);
				bad += check_field("last_duration", e.dur, last_duration);
				bad += check_field("stack_depth", e.depth, stack_depth);
				bad += check_field("entries_used", e.used, entries_used);
				bad += check_field("mismatch_count", e.mis, mismatch_count);
				bad += check_field("stack_full_count", e.sfull, stack_full_count);
				bad += check_field("table_full_count", e.tfull, table_full_count);
				failures += bad;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = cspa_pkg::CMD_READ;
		region_key = '0;
		timestamp = '0;
		read_index = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		failures = 0;
		quiet_cycles = 0;
		burst_left = 0;
		now_ts = '0;
		m_used = 0;
		m_depth = 0;
		m_mis = '0;
		m_sfull = '0;
		m_tfull = '0;
		m_strict = 1'b1;
		for (int i = 0; i < POOL; i++)
			key_pool[i] = $urandom;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		write_strict(1'b1);
		test_stack_full();
		test_random(400);
		test_recovery();
		test_random(400);
		write_strict(1'b1);
		test_random(100);
		test_table_full();

		drain();
		repeat (20) @(posedge clk);
		if (failures == 0 && expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
